>>> src/wbmp_pkg.sv
package wbmp_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_BOTTOM_UP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BITS   = 3'd4;
  localparam int CFG_DATA_W = 16;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Header layout: two zero bytes, then up to three groups per number
  localparam int HDR_IDX_W = 3;
  localparam int GRP_CNT_W = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [31:0] fetch_address;
    logic        fetch_valid;
    logic        image_done;
    logic        run_last;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] row_stride;
    logic        rows_bottom_up;
    logic        reverse_bits;
  } cfg_t;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       hdr_last;
  } hdr_info_t;

  // Mirror bit order within a byte
  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    a = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    b = ((a & 8'hCC) >> 2) | ((a & 8'h33) << 2);
    return ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
  endfunction

endpackage

>>> src/wbmp_type0_stream_formatter.sv
// Type 0 WBMP stream formatter for a 1-bpp page.
// Input channel (in_valid / in_stall / in_data): a start request (kind 0)
// makes the header run of 4 to 8 results: two zero bytes, then width and
// height as big-endian 7-bit groups. Its last result carries the first
// source fetch address. A data request (kind 1) carries one source byte and
// makes one result: the byte (mirrored if reverse_bits is set), the next
// fetch address, and image_done on the last byte of the page.
// Output channel (out_valid / out_stall / out_data): one result per cycle
// while out_stall is low. Configuration (cfg_we / cfg_index / cfg_wdata)
// must be written only while idle; the block itself does not enforce it.
// Requests pass the input register, then the result register. One data
// request is taken per cycle while out_stall is low; a start request holds
// the input as the header index counter steps once per result to its end.
// Reset: clears the page state and the two valid flags; registers return to
// width 1, height 1, stride 1, top-down, no mirroring.
// Receiver stall: the result register holds; the input register holds its
// request and in_stall rises once it is occupied, so nothing is lost.
module wbmp_type0_stream_formatter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wbmp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wbmp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [wbmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbmp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  wbmp_pkg::cfg_t      cfg;
  wbmp_pkg::hdr_info_t hdr;
  wbmp_pkg::in_item_t  stage_r;
  wbmp_pkg::out_item_t res;
  wbmp_pkg::out_item_t out_r;

  logic        stage_valid_r;
  logic        out_valid_r;
  logic [wbmp_pkg::HDR_IDX_W-1:0] hdr_idx_r;
  logic [wbmp_pkg::HDR_IDX_W-1:0] hdr_idx_nxt;
  logic        page_active_r, page_active_nxt;
  logic [15:0] row_count_r, row_count_nxt;
  logic [12:0] column_count_r, column_count_nxt;
  logic [31:0] row_base_r, row_base_nxt;

  logic        out_free;
  logic        res_last;
  logic        retire;
  logic        is_start;
  logic        cfg_bad;
  logic [13:0] row_bytes;
  logic [16:0] width_sum;
  logic [13:0] col_inc;
  logic [16:0] row_inc;
  logic        row_end;
  logic        page_end;
  logic [15:0] mul_row;
  logic [15:0] src_row;
  logic [31:0] base_new;
  logic [7:0]  data_byte;

  wbmp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  wbmp_hdr_gen u_hdr (
    .hdr_idx      (hdr_idx_r),
    .image_width  (cfg.image_width),
    .image_height (cfg.image_height),
    .hdr_o        (hdr)
  );

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign retire   = stage_valid_r && out_free && res_last;
  assign in_stall = stage_valid_r && !retire;
  assign is_start = (stage_r.kind == wbmp_pkg::KIND_START);
  assign cfg_bad  = (cfg.image_width == 16'd0) || (cfg.image_height == 16'd0) ||
                    (cfg.row_stride == 16'd0);

  // Row and page bookkeeping
  assign width_sum = {1'b0, cfg.image_width} + 17'd7;
  assign row_bytes = width_sum[16:3];
  assign col_inc   = {1'b0, column_count_r} + 14'd1;
  assign row_inc   = {1'b0, row_count_r} + 17'd1;
  assign row_end   = col_inc >= row_bytes;
  assign page_end  = row_inc >= {1'b0, cfg.image_height};

  // Shared row base multiplier: row 0 for a start, next row for data
  assign mul_row   = is_start ? 16'd0 : row_inc[15:0];
  assign src_row   = cfg.rows_bottom_up ? (cfg.image_height - 16'd1 - mul_row) : mul_row;
  assign base_new  = {16'd0, src_row} * {16'd0, cfg.row_stride};
  assign data_byte = cfg.reverse_bits ? wbmp_pkg::mirror8(stage_r.source_byte)
                                      : stage_r.source_byte;

  // Build the result and the state update for the staged request
  always_comb begin
    res              = '0;
    res_last         = 1'b1;
    hdr_idx_nxt      = hdr_idx_r;
    page_active_nxt  = page_active_r;
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    row_base_nxt     = row_base_r;
    if (is_start) begin
      if (cfg_bad) begin
        res.status      = wbmp_pkg::STATUS_REJECTED;
        res.run_last    = 1'b1;
        page_active_nxt = 1'b0;
        hdr_idx_nxt     = '0;
      end else begin
        res.out_byte   = hdr.hdr_byte;
        res.byte_valid = 1'b1;
        res_last       = hdr.hdr_last;
        hdr_idx_nxt    = hdr_idx_r + 3'd1;
        if (hdr.hdr_last) begin
          res.fetch_address = base_new;
          res.fetch_valid   = 1'b1;
          res.run_last      = 1'b1;
          hdr_idx_nxt       = '0;
          page_active_nxt   = 1'b1;
          row_count_nxt     = 16'd0;
          column_count_nxt  = 13'd0;
          row_base_nxt      = base_new;
        end
      end
    end else if (!page_active_r) begin
      res.status   = wbmp_pkg::STATUS_REJECTED;
      res.run_last = 1'b1;
    end else begin
      res.out_byte   = data_byte;
      res.byte_valid = 1'b1;
      res.run_last   = 1'b1;
      if (row_end) begin
        column_count_nxt = 13'd0;
        if (page_end) begin
          res.image_done  = 1'b1;
          page_active_nxt = 1'b0;
          row_count_nxt   = 16'd0;
          row_base_nxt    = 32'd0;
        end else begin
          res.fetch_address = base_new;
          res.fetch_valid   = 1'b1;
          row_count_nxt     = row_inc[15:0];
          row_base_nxt      = base_new;
        end
      end else begin
        res.fetch_address = row_base_r + {19'd0, col_inc[12:0]};
        res.fetch_valid   = 1'b1;
        column_count_nxt  = col_inc[12:0];
      end
    end
  end

  // Input register: load on accept, drop on retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid_r <= 1'b1;
    end else if (retire) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_r <= in_data;
    end
  end

  // Page state and header index advance with each delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r      <= '0;
      page_active_r  <= 1'b0;
      row_count_r    <= 16'd0;
      column_count_r <= 13'd0;
      row_base_r     <= 32'd0;
    end else if (stage_valid_r && out_free) begin
      hdr_idx_r      <= hdr_idx_nxt;
      page_active_r  <= page_active_nxt;
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
      row_base_r     <= row_base_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/wbmp_cfg_regs.sv
module wbmp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wbmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbmp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output wbmp_pkg::cfg_t                     cfg_o
);

  wbmp_pkg::cfg_t cfg_r;

  // Hold register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 16'd1;
      cfg_r.image_height   <= 16'd1;
      cfg_r.row_stride     <= 16'd1;
      cfg_r.rows_bottom_up <= 1'b0;
      cfg_r.reverse_bits   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbmp_pkg::CFG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_wdata;
        wbmp_pkg::CFG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_wdata;
        wbmp_pkg::CFG_ROW_STRIDE:     cfg_r.row_stride     <= cfg_wdata;
        wbmp_pkg::CFG_ROWS_BOTTOM_UP: cfg_r.rows_bottom_up <= cfg_wdata[0];
        wbmp_pkg::CFG_REVERSE_BITS:   cfg_r.reverse_bits   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> src/wbmp_hdr_gen.sv
module wbmp_hdr_gen (
  input  logic [wbmp_pkg::HDR_IDX_W-1:0] hdr_idx,
  input  logic [15:0]                    image_width,
  input  logic [15:0]                    image_height,
  output wbmp_pkg::hdr_info_t            hdr_o
);

  logic [wbmp_pkg::GRP_CNT_W-1:0] w_groups;
  logic [wbmp_pkg::GRP_CNT_W-1:0] h_groups;
  logic [wbmp_pkg::HDR_IDX_W-1:0] rel_idx;
  logic [wbmp_pkg::HDR_IDX_W-1:0] w_groups_x;
  logic [wbmp_pkg::HDR_IDX_W-1:0] h_groups_x;
  logic [wbmp_pkg::HDR_IDX_W-1:0] grp_sel;
  logic [15:0]                    num;
  logic [6:0]                     grp_bits;

  // Count 7-bit groups of each number
  always_comb begin
    if (image_width < 16'h0080)       w_groups = 2'd1;
    else if (image_width < 16'h4000)  w_groups = 2'd2;
    else                              w_groups = 2'd3;
    if (image_height < 16'h0080)      h_groups = 2'd1;
    else if (image_height < 16'h4000) h_groups = 2'd2;
    else                              h_groups = 2'd3;
  end

  assign w_groups_x = {1'b0, w_groups};
  assign h_groups_x = {1'b0, h_groups};
  assign rel_idx    = hdr_idx - 3'd2;

  // Pick number and group, most significant group first
  always_comb begin
    if (rel_idx < w_groups_x) begin
      num     = image_width;
      grp_sel = w_groups_x - 3'd1 - rel_idx;
    end else begin
      num     = image_height;
      grp_sel = h_groups_x - 3'd1 - (rel_idx - w_groups_x);
    end
    unique case (grp_sel[1:0])
      2'd0:    grp_bits = num[6:0];
      2'd1:    grp_bits = num[13:7];
      default: grp_bits = {5'd0, num[15:14]};
    endcase
  end

  // Leading zero bytes, then groups with continuation flag
  always_comb begin
    if (hdr_idx < 3'd2) hdr_o.hdr_byte = 8'h00;
    else                hdr_o.hdr_byte = {(grp_sel != 3'd0), grp_bits};
    hdr_o.hdr_last = (hdr_idx == (3'd1 + w_groups_x + h_groups_x));
  end

endmodule

>>> src/wbmp_checker.sv
module wbmp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wbmp_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Header bytes follow each other without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=> out_valid)
    else $error("gap inside a header run");

  // A stalled header run keeps the input stalled
  a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !out_data.run_last && in_valid |-> in_stall)
    else $error("input accepted during a stalled header run");

  // Final image byte ends the run with no further fetch
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_done |->
      out_data.run_last && out_data.byte_valid && !out_data.fetch_valid)
    else $error("bad final image byte");

  // Rejected requests carry no stream byte and no fetch
  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == wbmp_pkg::STATUS_REJECTED) |->
      out_data.run_last && !out_data.byte_valid && !out_data.fetch_valid)
    else $error("bad rejected result");

endmodule

bind wbmp_type0_stream_formatter wbmp_checker u_wbmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
